FILE: src/wrrd_pkg.sv
// ----------------------------------------------------------------------------
// wrrd_pkg
// Shared types and constants of the weighted round-robin dispatcher.
// ----------------------------------------------------------------------------
package wrrd_pkg;

	localparam int NODES_DEF   = 8;
	localparam int WORKERS_DEF = 8;
	localparam int WGT_W       = 16;
	localparam int SHIFT_W     = 4;

	localparam logic OP_DISPATCH   = 1'b0;
	localparam logic OP_SET_WEIGHT = 1'b1;

	localparam logic [1:0] ST_CHOSEN  = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_UPDATED = 2'd2;

	typedef struct packed {
		logic [WGT_W-1:0] diff;
		logic             borrow;
		logic             zero;
	} sub_res_t;

endpackage

FILE: src/wrrd_sub.sv
// ----------------------------------------------------------------------------
// wrrd_sub
// Shared subtract and compare unit: a - b with borrow and zero flags.
// ----------------------------------------------------------------------------
module wrrd_sub (
	input  logic [wrrd_pkg::WGT_W-1:0] a,
	input  logic [wrrd_pkg::WGT_W-1:0] b,
	output wrrd_pkg::sub_res_t         res
);

	logic [wrrd_pkg::WGT_W:0] full;

	assign full       = {1'b0, a} - {1'b0, b};
	assign res.diff   = full[wrrd_pkg::WGT_W-1:0];
	assign res.borrow = full[wrrd_pkg::WGT_W];
	assign res.zero   = (full == '0);

endmodule

FILE: src/wrrd_wmem.sv
// ----------------------------------------------------------------------------
// wrrd_wmem
// Node weight store: one write port, one registered read port, entries
// read as zero until written.
// ----------------------------------------------------------------------------
module wrrd_wmem #(
	parameter int NODES = wrrd_pkg::NODES_DEF,
	parameter int AW    = $clog2(NODES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [wrrd_pkg::WGT_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [wrrd_pkg::WGT_W-1:0] rdata
);

	logic [wrrd_pkg::WGT_W-1:0] mem [NODES];
	logic [NODES-1:0]           vld_q;
	logic [wrrd_pkg::WGT_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

FILE: src/weighted_round_robin_dispatch_top.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_dispatch_top
// Weighted round-robin picker with a private position per worker. A small
// sequencer drives one shared subtractor for binary gcd and credit checks.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  opcode, worker, node_slot, new_weight
//   out      out  out_valid/ out_stall chosen_node, status
//
// dispatch: a read and a credit check, plus a read and a check per slot
//   walked (up to NODES) when credit is short; weight reads are registered
// weight update: a write, then a read and check of every slot, with binary
//   gcd steps for each further nonzero weight, all on the one subtractor
// one beat at a time; in_stall is high until the result is in the output
//   register, which a stalled out side holds while a new beat is taken
// reset clears control and valid bits at once; no clearing pass
// ----------------------------------------------------------------------------
module weighted_round_robin_dispatch_top #(
	parameter int NODES   = wrrd_pkg::NODES_DEF,
	parameter int WORKERS = wrrd_pkg::WORKERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [2:0]                 worker,
	input  logic [2:0]                 node_slot,
	input  logic [wrrd_pkg::WGT_W-1:0] new_weight,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 chosen_node,
	output logic [1:0]                 status
);

	localparam int NIDX = $clog2(NODES);
	localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam logic [NIDX-1:0] LAST_NODE = NIDX'(NODES - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UPD_WR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_GCD,
		S_UPD_FIN,
		S_DSP_RD,
		S_DSP_CHK,
		S_WALK_RD,
		S_WALK_CHK,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [2:0]                 wk_q;
	logic [2:0]                 slot_q;
	logic [wrrd_pkg::WGT_W-1:0] wt_q;

	logic [wrrd_pkg::WGT_W-1:0] gcd_q;
	logic                       base_found_q;
	logic [NIDX-1:0]            base_first_q;
	logic [wrrd_pkg::WGT_W-1:0] base_credit_q;
	logic [WORKERS-1:0]         dirty_q;

	logic [NIDX-1:0]            si_q;
	logic                       found_q;
	logic [NIDX-1:0]            first_q;
	logic [wrrd_pkg::WGT_W-1:0] first_w_q;
	logic [wrrd_pkg::WGT_W-1:0] g_q;
	logic [wrrd_pkg::WGT_W-1:0] ga_q;
	logic [wrrd_pkg::WGT_W-1:0] gb_q;
	logic [wrrd_pkg::SHIFT_W-1:0] gk_q;

	logic [NIDX-1:0]            cur_q;
	logic [NIDX-1:0]            start_q;

	logic [1:0]                 res_status_q;
	logic [2:0]                 res_node_q;
	logic                       out_valid_q;
	logic [2:0]                 chosen_node_q;
	logic [1:0]                 status_q;

	logic [NIDX-1:0]            wnode_mem [WORKERS];
	logic [wrrd_pkg::WGT_W-1:0] wcred_mem [WORKERS];
	logic [NIDX-1:0]            wnode_rd_q;
	logic [wrrd_pkg::WGT_W-1:0] wcred_rd_q;

	logic [WIDX-1:0]            wk_idx;
	logic                       sel_has;
	logic [NIDX-1:0]            sel_node;
	logic [wrrd_pkg::WGT_W-1:0] sel_credit;
	logic                       wm_we;
	logic [NIDX-1:0]            wm_node;
	logic [NIDX-1:0]            w_raddr;
	logic [wrrd_pkg::WGT_W-1:0] w_rdata;
	logic [wrrd_pkg::WGT_W-1:0] op_a;
	logic [wrrd_pkg::WGT_W-1:0] op_b;
	wrrd_pkg::sub_res_t         sub;
	logic [NIDX-1:0]            si_next;
	logic [NIDX-1:0]            sel_next;
	logic [NIDX-1:0]            cur_next;
	logic                       in_acc;

	assign wk_idx     = WIDX'(wk_q);
	assign sel_has    = dirty_q[wk_idx] | base_found_q;
	assign sel_node   = dirty_q[wk_idx] ? wnode_rd_q : base_first_q;
	assign sel_credit = dirty_q[wk_idx] ? wcred_rd_q : base_credit_q;
	assign si_next    = si_q + NIDX'(1);
	assign sel_next   = (sel_node == LAST_NODE) ? '0 : sel_node + NIDX'(1);
	assign cur_next   = (cur_q == LAST_NODE) ? '0 : cur_q + NIDX'(1);
	assign w_raddr    = (state_q == S_WALK_RD) ? cur_q : si_q;
	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid & ~in_stall;

	always_comb begin
		case (state_q)
			S_GCD: begin
				op_a = ga_q;
				op_b = gb_q;
			end
			S_DSP_CHK: begin
				op_a = sel_credit;
				op_b = gcd_q;
			end
			S_WALK_CHK: begin
				op_a = w_rdata;
				op_b = gcd_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign wm_we   = ((state_q == S_DSP_CHK) && sel_has && !sub.borrow) ||
	                 ((state_q == S_WALK_CHK) && !sub.borrow);
	assign wm_node = (state_q == S_DSP_CHK) ? sel_node : cur_q;

	wrrd_sub u_sub (
		.a   (op_a),
		.b   (op_b),
		.res (sub)
	);

	wrrd_wmem #(
		.NODES (NODES),
		.AW    (NIDX)
	) u_wmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (state_q == S_UPD_WR),
		.waddr  (NIDX'(slot_q)),
		.wdata  (wt_q),
		.raddr  (w_raddr),
		.rdata  (w_rdata)
	);

	always_ff @(posedge clk) begin
		if (wm_we) begin
			wnode_mem[wk_idx] <= wm_node;
			wcred_mem[wk_idx] <= sub.diff;
		end
		wnode_rd_q <= wnode_mem[wk_idx];
		wcred_rd_q <= wcred_mem[wk_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			gcd_q         <= 16'd1;
			base_found_q  <= 1'b0;
			base_first_q  <= '0;
			base_credit_q <= '0;
			dirty_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			if (wm_we) begin
				dirty_q[wk_idx] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						wk_q       <= worker;
						slot_q     <= node_slot;
						wt_q       <= new_weight;
						res_node_q <= 3'd0;
						if (opcode == wrrd_pkg::OP_SET_WEIGHT) begin
							res_status_q <= wrrd_pkg::ST_UPDATED;
							if (7'(node_slot) < 7'(NODES)) begin
								state_q <= S_UPD_WR;
							end else begin
								state_q <= S_FINISH;
							end
						end else begin
							res_status_q <= wrrd_pkg::ST_NONE;
							if (7'(worker) < 7'(WORKERS)) begin
								state_q <= S_DSP_RD;
							end else begin
								state_q <= S_FINISH;
							end
						end
					end
				end
				S_UPD_WR: begin
					si_q    <= '0;
					found_q <= 1'b0;
					first_q <= '0;
					first_w_q <= '0;
					g_q     <= '0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (w_rdata != '0 && found_q) begin
						ga_q    <= g_q;
						gb_q    <= w_rdata;
						gk_q    <= '0;
						state_q <= S_GCD;
					end else begin
						if (w_rdata != '0) begin
							found_q   <= 1'b1;
							first_q   <= si_q;
							first_w_q <= w_rdata;
							g_q       <= w_rdata;
						end
						si_q    <= si_next;
						state_q <= (si_q == LAST_NODE) ? S_UPD_FIN : S_SCAN_RD;
					end
				end
				S_GCD: begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gk_q <= gk_q + wrrd_pkg::SHIFT_W'(1);
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (sub.zero) begin
						g_q     <= gb_q << gk_q;
						si_q    <= si_next;
						state_q <= (si_q == LAST_NODE) ? S_UPD_FIN : S_SCAN_RD;
					end else if (sub.borrow) begin
						ga_q <= gb_q;
						gb_q <= ga_q;
					end else begin
						ga_q <= sub.diff;
					end
				end
				S_UPD_FIN: begin
					gcd_q         <= found_q ? g_q : 16'd1;
					base_found_q  <= found_q;
					base_first_q  <= first_q;
					base_credit_q <= first_w_q;
					dirty_q       <= '0;
					state_q       <= S_FINISH;
				end
				S_DSP_RD: begin
					state_q <= S_DSP_CHK;
				end
				S_DSP_CHK: begin
					start_q <= sel_node;
					cur_q   <= sel_next;
					if (!sel_has) begin
						state_q <= S_FINISH;
					end else if (!sub.borrow) begin
						res_status_q <= wrrd_pkg::ST_CHOSEN;
						res_node_q   <= 3'(sel_node);
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (!sub.borrow) begin
						res_status_q <= wrrd_pkg::ST_CHOSEN;
						res_node_q   <= 3'(cur_q);
						state_q      <= S_FINISH;
					end else if (cur_q == start_q) begin
						state_q <= S_FINISH;
					end else begin
						cur_q   <= cur_next;
						state_q <= S_WALK_RD;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						chosen_node_q <= res_node_q;
						status_q      <= res_status_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_node = chosen_node_q;
	assign status      = status_q;

`ifndef SYNTH
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_q != '0)
		else $error("gcd register is zero");

	a_gcd_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD) |-> (ga_q != '0 && gb_q != '0))
		else $error("gcd operand reached zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("new beat taken while busy");

	a_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != wrrd_pkg::ST_CHOSEN) |-> (chosen_node == 3'd0))
		else $error("chosen node set without a pick");
`endif

endmodule

FILE: tb/weighted_round_robin_dispatch_top_tb.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_dispatch_top_tb
// Self-checking bench for the weighted round-robin dispatcher. A scoreboard
// keeps its own copy of the slot weights, the gcd and every worker's position
// and credit, predicts the pick or update status of each input beat and
// compares it with the output beats in order. Directed beats cover removal,
// extreme weights and the wrap of the slot walk. Random beats mix weight
// updates around a shared factor with dispatches, and random gaps and stalls
// fall on both channels, with one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module weighted_round_robin_dispatch_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WGT_W       = wrrd_pkg::WGT_W;
	localparam int N_SLOTS     = 8;
	localparam int N_WORKERS   = 8;
	localparam int RAND_BEATS  = 1700;
	localparam int HOLD_CYCLES = 1500;
	localparam int IDLE_LIMIT  = 20000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [2:0] node;
		logic [1:0] status;
	} pick_t;

	class wrr_scoreboard;
		logic [WGT_W-1:0] slot_weight[N_SLOTS];
		logic [WGT_W-1:0] wgt_gcd;
		logic [2:0]       cur_node[N_WORKERS];
		bit               has_node[N_WORKERS];
		logic [WGT_W-1:0] credit[N_WORKERS];
		pick_t            pick_q[$];
		int               errors;

		function new();
			for (int i = 0; i < N_SLOTS; i++) slot_weight[i] = '0;
			for (int i = 0; i < N_WORKERS; i++) begin
				cur_node[i] = '0;
				has_node[i] = 1'b0;
				credit[i]   = '0;
			end
			wgt_gcd = 1;
			errors  = 0;
		endfunction

		function void rebuild_rotation();
			int g;
			int a;
			int b;
			int r;
			bit found;
			int first;
			int first_w;
			g       = 0;
			found   = 1'b0;
			first   = 0;
			first_w = 0;
			for (int i = 0; i < N_SLOTS; i++) begin
				if (slot_weight[i] != 0) begin
					if (g == 0) begin
						g = int'(slot_weight[i]);
					end else begin
						a = g;
						b = int'(slot_weight[i]);
						while (b != 0) begin
							r = a % b;
							a = b;
							b = r;
						end
						g = a;
					end
					if (!found) begin
						found   = 1'b1;
						first   = i;
						first_w = int'(slot_weight[i]);
					end
				end
			end
			wgt_gcd = (g != 0) ? WGT_W'(g) : WGT_W'(1);
			for (int i = 0; i < N_WORKERS; i++) begin
				cur_node[i] = 3'(first);
				has_node[i] = found;
				credit[i]   = WGT_W'(first_w);
			end
		endfunction

		function void note_beat(logic op, logic [2:0] wk, logic [2:0] sl, logic [WGT_W-1:0] wt);
			pick_t p;
			int cw;
			int cur;
			int start;
			bit hit;
			p.node   = '0;
			p.status = wrrd_pkg::ST_NONE;
			if (op == wrrd_pkg::OP_SET_WEIGHT) begin
				slot_weight[sl] = wt;
				rebuild_rotation();
				p.status = wrrd_pkg::ST_UPDATED;
			end else if (has_node[wk]) begin
				start = int'(cur_node[wk]);
				cur   = start;
				cw    = int'(credit[wk]) - int'(wgt_gcd);
				hit   = (cw >= 0);
				if (!hit) begin
					for (int n = 0; n < N_SLOTS; n++) begin
						cur = (cur + 1 >= N_SLOTS) ? 0 : cur + 1;
						cw  = int'(slot_weight[cur]) - int'(wgt_gcd);
						if (cw >= 0) begin
							hit = 1'b1;
							break;
						end
						if (cur == start) break;
					end
				end
				if (hit) begin
					credit[wk]   = WGT_W'(cw);
					cur_node[wk] = 3'(cur);
					p.node       = 3'(cur);
					p.status     = wrrd_pkg::ST_CHOSEN;
				end
			end
			pick_q.push_back(p);
		endfunction

		function void check_result(logic [2:0] node, logic [1:0] status);
			pick_t p;
			if (pick_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: node %0d status %0d", node, status);
				return;
			end
			p = pick_q.pop_front();
			if (node !== p.node || status !== p.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected node %0d status %0d, got node %0d status %0d",
						p.node, p.status, node, status);
			end
		endfunction

		function int pending();
			return pick_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic             opcode     = wrrd_pkg::OP_DISPATCH;
	logic [2:0]       worker     = '0;
	logic [2:0]       node_slot  = '0;
	logic [WGT_W-1:0] new_weight = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [2:0]       chosen_node;
	logic [1:0]       status;

	wrr_scoreboard sb;
	int  in_beats      = 0;
	int  idle_cycles   = 0;
	bit  tx_no_gap     = 1'b0;
	bit  pressure_done = 1'b0;

	weighted_round_robin_dispatch_top #(
		.NODES  (N_SLOTS),
		.WORKERS(N_WORKERS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.worker     (worker),
		.node_slot  (node_slot),
		.new_weight (new_weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chosen_node(chosen_node),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(16, 120);
	endfunction

	// accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_beat(opcode, worker, node_slot, new_weight);
				in_beats++;
			end
			if (out_valid && !out_stall)
				sb.check_result(chosen_node, status);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_beat(logic op, logic [2:0] wk, logic [2:0] sl, logic [WGT_W-1:0] wt);
		int gap;
		in_valid   <= 1'b1;
		opcode     <= op;
		worker     <= wk;
		node_slot  <= sl;
		new_weight <= wt;
		do @(posedge clk); while (in_stall);
		gap = tx_no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic dispatch(logic [2:0] wk);
		send_beat(wrrd_pkg::OP_DISPATCH, wk, 3'($urandom), WGT_W'($urandom));
	endtask

	task automatic set_weight(logic [2:0] sl, logic [WGT_W-1:0] wt);
		send_beat(wrrd_pkg::OP_SET_WEIGHT, 3'($urandom), sl, wt);
	endtask

	// output side: random stalls, quiet stretches and one long hold
	initial begin
		int r;
		wait (arst_n);
		forever begin
			if (!pressure_done && in_beats >= 600) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(50, 200)) @(posedge clk);
				end else if (r < 55) begin
					out_stall <= 1'b1;
					repeat (pick_gap() + 1) @(posedge clk);
				end else begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [WGT_W-1:0] base;
		logic [WGT_W-1:0] wt;
		int               r;
		wait (arst_n);
		@(posedge clk);

		// directed: empty rotation, extremes, removal and walk wrap
		dispatch(3'd0);
		set_weight(3'd7, 16'h0000);
		dispatch(3'd7);
		set_weight(3'd3, 16'hFFFF);
		dispatch(3'd0);
		dispatch(3'd7);
		set_weight(3'd0, 16'h0001);
		dispatch(3'd1);
		dispatch(3'd1);
		dispatch(3'd1);
		set_weight(3'd3, 16'h0000);
		dispatch(3'd2);
		dispatch(3'd2);
		set_weight(3'd0, 16'd4);
		set_weight(3'd5, 16'd6);
		set_weight(3'd7, 16'h8000);
		set_weight(3'd7, 16'h0000);
		repeat (5) dispatch(3'd4);
		set_weight(3'd0, 16'h0000);
		set_weight(3'd5, 16'h0000);
		dispatch(3'd4);

		base = 1;
		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i % 150 == 0) begin
				tx_no_gap = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 5))
					0: base = 1;
					1: base = 2;
					2: base = 3;
					3: base = 6;
					4: base = WGT_W'($urandom_range(1, 16));
					default: base = WGT_W'($urandom_range(256, 4096));
				endcase
			end
			if ($urandom_range(0, 99) < 22) begin
				r = $urandom_range(0, 99);
				if (r < 15) wt = '0;
				else if (r < 25) wt = WGT_W'($urandom);
				else if (r < 28) wt = 16'hFFFF;
				else wt = WGT_W'(base * $urandom_range(1, 5));
				set_weight(3'($urandom), wt);
			end else begin
				dispatch(3'($urandom));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
